// ===== hdl/bpmc_pkg.sv =====
// shared constants and types of the perfect matching counter
package bpmc_pkg;

  localparam int unsigned CountW = 30;
  localparam logic [CountW-1:0] PrimeMod = 30'd1000000007;

  localparam int unsigned RowSlots = 16;
  localparam int unsigned RowIdxW  = 4;
  localparam int unsigned RowW     = 16;
  localparam int unsigned SizeW    = 5;
  localparam logic [SizeW-1:0] SizeReset = 5'd16;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // register index, taken from paddr[2]
  localparam logic RegMatrixSize = 1'b0;

  typedef logic [CountW-1:0] count_t;
  typedef logic [RowW-1:0]   row_t;

endpackage

// ===== hdl/bipartite_perfect_matching_count.sv =====
// a last-row request starts the count, walking every nonempty subset and, for each, every vertex
// throughput: rows that are not last are taken one per cycle; a last row blocks input until the
// count is finished and handed to the output register
// reset: rst_ni is asynchronous and active low; control state and matrix_size (16) clear,
// rows and table memory hold no reset value; the table is written before it is read, while
// the user must write each row before a count reads it, which the block does not enforce
module bipartite_perfect_matching_count
  import bpmc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side: [3:0] row_index, [19:4] row_bits, [23:20] zero
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tlast_i,
  // master side: [29:0] match_count, [31:30] zero
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // configuration
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  output logic [ApbDataW-1:0] prdata_o,
  output logic                pready_o
);

  localparam int unsigned AW = MAX_VERTICES;
  localparam int unsigned JW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned PcW = $clog2(MAX_VERTICES + 1) > 0 ? $clog2(MAX_VERTICES + 1) : 1;
  localparam logic [SizeW-1:0] MaxV = SizeW'(MAX_VERTICES);

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StLoad,
    StScan,
    StDrain,
    StEmit
  } state_e;

  state_e             state_q;
  logic [SizeW-1:0]   size_q;
  logic [AW-1:0]      s_q;
  logic [AW-1:0]      full_q;
  logic [JW-1:0]      j_q;
  logic [JW-1:0]      j_last_q;
  count_t             acc_q;
  row_t               row_q;
  logic               rd_pend_q;
  logic               out_valid_q;
  count_t             result_q;

  row_t               rows_q [RowSlots];
  count_t             cnt_mem [2**AW];
  count_t             rd_data_q;

  logic               in_acc;
  logic               cfg_wr;
  logic [SizeW-1:0]   n_c;
  logic [AW-1:0]      full_c;
  logic [PcW-1:0]     pc_c;
  logic [PcW-1:0]     k_c;
  logic [SizeW-1:0]   j_ext;
  logic               term_c;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  count_t             wr_data;
  logic [CountW:0]    sum_c;
  count_t             acc_sum;
  logic               out_free;

  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - CountW){1'b0}}, result_q};
  assign out_free        = ~out_valid_q | m_axis_tready_i;

  // configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & pready_o;
  assign prdata_o = (paddr_i[2] == RegMatrixSize) ?
                    {{(ApbDataW - SizeW){1'b0}}, size_q} : '0;

  // clamp n into one to MAX_VERTICES
  always_comb begin
    if (size_q == '0) begin
      n_c = SizeW'(1);
    end else if (size_q > MaxV) begin
      n_c = MaxV;
    end else begin
      n_c = size_q;
    end
  end

  assign full_c = {AW{1'b1}} >> (MaxV - n_c);

  // left row taken by a subset is its popcount minus one
  assign pc_c = PcW'($countones(s_q));
  assign k_c  = pc_c - PcW'(1);

  assign j_ext  = SizeW'(j_q);
  assign term_c = s_q[j_q] & ~j_ext[4] & row_q[j_ext[3:0]];

  assign rd_en   = (state_q == StScan) & term_c;
  assign rd_addr = s_q ^ (AW'(1) << j_q);

  assign sum_c   = {1'b0, acc_q} + {1'b0, (rd_pend_q ? rd_data_q : count_t'(0))};
  assign acc_sum = (sum_c >= {1'b0, PrimeMod}) ? CountW'(sum_c - {1'b0, PrimeMod})
                                               : sum_c[CountW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s_q;
    wr_data = acc_sum;
    case (state_q)
      StInit: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = count_t'(1);
      end
      StDrain: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // subset count table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= cnt_mem[rd_addr];
    end
  end

  // compatibility rows
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rows_q[s_axis_tdata_i[RowIdxW-1:0]] <= s_axis_tdata_i[RowIdxW +: RowW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_wr && paddr_i[2] == RegMatrixSize) begin
      size_q <= pwdata_i[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      s_q         <= '0;
      full_q      <= '0;
      j_q         <= '0;
      j_last_q    <= '0;
      acc_q       <= '0;
      row_q       <= '0;
      result_q    <= '0;
    end else begin
      // the finished count moves to the output register only once it is free
      if (state_q == StEmit && out_free) begin
        out_valid_q <= 1'b1;
        result_q    <= acc_q;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      rd_pend_q <= rd_en;
      case (state_q)
        StIdle: begin
          if (in_acc && s_axis_tlast_i) begin
            state_q <= StInit;
          end
        end
        StInit: begin
          full_q   <= full_c;
          j_last_q <= JW'(n_c - SizeW'(1));
          s_q      <= AW'(1);
          state_q  <= StLoad;
        end
        StLoad: begin
          row_q   <= (k_c < PcW'(RowSlots)) ? rows_q[k_c[RowIdxW-1:0]] : '0;
          j_q     <= '0;
          acc_q   <= '0;
          state_q <= StScan;
        end
        StScan: begin
          acc_q <= acc_sum;
          if (j_q == j_last_q) begin
            state_q <= StDrain;
          end else begin
            j_q <= j_q + JW'(1);
          end
        end
        StDrain: begin
          acc_q <= acc_sum;
          if (s_q == full_q) begin
            state_q <= StEmit;
          end else begin
            s_q     <= s_q + AW'(1);
            state_q <= StLoad;
          end
        end
        StEmit: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== hdl/bpmc_checker.sv =====
// port-level checks of the perfect matching counter, bound to the top level
module bpmc_checker
  import bpmc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                s_axis_tlast_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // a last row starts the count, so input closes at once
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input still open after last-row request");

  // a plain row request leaves the block ready for the next one
  a_row_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tlast_i |=> s_axis_tready_o)
    else $error("input closed after plain row request");

  // result is always reduced
  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[CountW-1:0] < PrimeMod) &&
                        (m_axis_tdata_o[OutDataW-1:CountW] == '0))
    else $error("result not reduced");

  // stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind bipartite_perfect_matching_count bpmc_checker u_bpmc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
